// ===== src/sgst_pkg.sv =====
// Shared types, constants and codes for the shifter gate state tracker.
package sgst_pkg;

    // Axis geometry and the fixed exit depth of the synchro tracker.
    localparam int AXIS_MAX         = 65535;
    localparam int AXIS_MID         = AXIS_MAX / 2;
    localparam int EXIT_SYNCH_DEPTH = 16000;

    // Signed working width: covers thresholds that fall beyond either axis end.
    localparam int SW_W = 18;
    typedef logic signed [SW_W-1:0] t_sw;

    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes on the configuration port.
    localparam t_cfg_idx CFG_TELEMETRY    = 3'd0;
    localparam t_cfg_idx CFG_NEUTRAL_HW   = 3'd1;
    localparam t_cfg_idx CFG_SIDE_W       = 3'd2;
    localparam t_cfg_idx CFG_MIDDLE_HW    = 3'd3;
    localparam t_cfg_idx CFG_BZ_DEPTH     = 3'd4;
    localparam t_cfg_idx CFG_BZ_DEPTH_TEL = 3'd5;
    localparam t_cfg_idx CFG_SYNCH_DEPTH  = 3'd6;
    localparam t_cfg_idx CFG_GRIND_DEPTH  = 3'd7;

    // Slot codes.
    localparam logic [2:0] SLOT_UNKNOWN = 3'd0;
    localparam logic [2:0] SLOT_NEUTRAL = 3'd1;
    localparam logic [2:0] SLOT_LF      = 3'd2;
    localparam logic [2:0] SLOT_LB      = 3'd3;
    localparam logic [2:0] SLOT_MF      = 3'd4;
    localparam logic [2:0] SLOT_MB      = 3'd5;
    localparam logic [2:0] SLOT_RF      = 3'd6;
    localparam logic [2:0] SLOT_RB      = 3'd7;

    // Button zone codes.
    localparam logic [2:0] ZONE_NONE = 3'd0;
    localparam logic [2:0] ZONE_LF   = 3'd1;
    localparam logic [2:0] ZONE_LB   = 3'd2;
    localparam logic [2:0] ZONE_MF   = 3'd3;
    localparam logic [2:0] ZONE_MB   = 3'd4;
    localparam logic [2:0] ZONE_RF   = 3'd5;
    localparam logic [2:0] ZONE_RB   = 3'd6;

    // Synchro codes.
    localparam logic [1:0] SYN_UNKNOWN = 2'd0;
    localparam logic [1:0] SYN_IN      = 2'd1;
    localparam logic [1:0] SYN_EXIT    = 2'd2;
    localparam logic [1:0] SYN_ENTER   = 2'd3;

    typedef struct packed {
        logic              telemetry_active;
        logic [CFG_W-1:0]  neutral_half_width;
        logic [CFG_W-1:0]  side_w;
        logic [CFG_W-1:0]  mid_half_w;
        logic [CFG_W-1:0]  bz_depth;
        logic [CFG_W-1:0]  bz_depth_tel;
        logic [CFG_W-1:0]  synch_depth;
        logic [CFG_W-1:0]  grind_depth;
    } t_cfg;

    typedef struct packed {
        logic [15:0] lr_position;
        logic [15:0] fb_position;
        logic [7:0]  gear_a;
        logic [7:0]  gear_b;
    } t_sample;

    // Position flags of one sample, independent of tracker state.
    typedef struct packed {
        logic [2:0] slot;
        logic       fwd_zone;
        logic       back_zone;
        logic       tel_lock;
        logic       synch_near;
        logic       exit_near;
        logic       grind_near;
    } t_class;

    typedef struct packed {
        logic [2:0] slot_code;
        logic       slot_changed;
        logic [2:0] button_zone;
        logic       zone_changed;
        logic [1:0] synchro_code;
        logic       synchro_changed;
        logic       grinding;
        logic       grinding_changed;
    } t_result;

endpackage

// ===== src/sgst_in_if.sv =====
// Sample channel: valid/ready handshake with stick and gear payload.
interface sgst_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] lr_position;
    logic [15:0] fb_position;
    logic [7:0]  gear_a;
    logic [7:0]  gear_b;

    modport source (output valid, lr_position, fb_position, gear_a, gear_b, input ready);
    modport sink   (input valid, lr_position, fb_position, gear_a, gear_b, output ready);
endinterface

// ===== src/sgst_out_if.sv =====
// Result channel: valid/ready handshake with the tracker state payload.
interface sgst_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] slot_code;
    logic       slot_changed;
    logic [2:0] button_zone;
    logic       zone_changed;
    logic [1:0] synchro_code;
    logic       synchro_changed;
    logic       grinding;
    logic       grinding_changed;

    modport source (output valid, slot_code, slot_changed, button_zone, zone_changed,
                    synchro_code, synchro_changed, grinding, grinding_changed,
                    input ready);
    modport sink   (input valid, slot_code, slot_changed, button_zone, zone_changed,
                    synchro_code, synchro_changed, grinding, grinding_changed,
                    output ready);
endinterface

// ===== src/sgst_cfg_regs.sv =====
// Configuration register file with reset defaults.
module sgst_cfg_regs
    import sgst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  t_cfg_idx         i_idx,
    input  logic [CFG_W-1:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.telemetry_active   <= 1'b0;
            r_cfg.neutral_half_width <= CFG_W'(4000);
            r_cfg.side_w             <= CFG_W'(12000);
            r_cfg.mid_half_w         <= CFG_W'(6000);
            r_cfg.bz_depth           <= CFG_W'(3000);
            r_cfg.bz_depth_tel       <= CFG_W'(6000);
            r_cfg.synch_depth        <= CFG_W'(8000);
            r_cfg.grind_depth        <= CFG_W'(12000);
        end else if (i_we) begin
            case (i_idx)
                CFG_TELEMETRY:    r_cfg.telemetry_active   <= i_data[0];
                CFG_NEUTRAL_HW:   r_cfg.neutral_half_width <= i_data;
                CFG_SIDE_W:       r_cfg.side_w             <= i_data;
                CFG_MIDDLE_HW:    r_cfg.mid_half_w         <= i_data;
                CFG_BZ_DEPTH:     r_cfg.bz_depth           <= i_data;
                CFG_BZ_DEPTH_TEL: r_cfg.bz_depth_tel       <= i_data;
                CFG_SYNCH_DEPTH:  r_cfg.synch_depth        <= i_data;
                CFG_GRIND_DEPTH:  r_cfg.grind_depth        <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sgst_classify.sv =====
// Position classifier: gate slot and depth window flags for one sample.
module sgst_classify
    import sgst_pkg::*;
#(
    parameter int P_AXIS_MAX         = AXIS_MAX,
    parameter int P_EXIT_SYNCH_DEPTH = EXIT_SYNCH_DEPTH
)
(
    input  t_cfg    i_cfg,
    input  t_sample i_sample,
    output t_class  o_class
);

    localparam t_sw AXIS_MAX_S   = t_sw'(P_AXIS_MAX);
    localparam t_sw AXIS_MID_S   = t_sw'(P_AXIS_MAX / 2);
    localparam t_sw EXIT_DEPTH_S = t_sw'(P_EXIT_SYNCH_DEPTH);

    // True when v lies within depth of either end of the axis.
    function automatic logic near_end(input t_sw v, input t_sw depth);
        return (v <= depth) || (v >= AXIS_MAX_S - depth);
    endfunction

    function automatic t_sw ext15(input logic [CFG_W-1:0] x);
        return $signed({{(SW_W-CFG_W){1'b0}}, x});
    endfunction

    t_sw lr;
    t_sw fb;
    t_sw nhw;
    t_sw side;
    t_sw mhw;
    t_sw bz;
    t_sw bzt;
    logic fwd;
    logic tel;

    always_comb begin
        lr   = $signed({{(SW_W-16){1'b0}}, i_sample.lr_position});
        fb   = $signed({{(SW_W-16){1'b0}}, i_sample.fb_position});
        nhw  = ext15(i_cfg.neutral_half_width);
        side = ext15(i_cfg.side_w);
        mhw  = ext15(i_cfg.mid_half_w);
        bz   = ext15(i_cfg.bz_depth);
        bzt  = ext15(i_cfg.bz_depth_tel);
        tel  = i_cfg.telemetry_active;
        fwd  = (fb <= AXIS_MID_S);

        // Neutral channel wins, then left, middle and right in that order.
        if ((fb <= AXIS_MID_S + nhw) && (fb >= AXIS_MID_S - nhw)) begin
            o_class.slot = SLOT_NEUTRAL;
        end else if (lr <= side) begin
            o_class.slot = fwd ? SLOT_LF : SLOT_LB;
        end else if ((lr >= AXIS_MID_S - mhw) && (lr <= AXIS_MID_S + mhw)) begin
            o_class.slot = fwd ? SLOT_MF : SLOT_MB;
        end else if (lr >= AXIS_MAX_S - side) begin
            o_class.slot = fwd ? SLOT_RF : SLOT_RB;
        end else begin
            o_class.slot = SLOT_UNKNOWN;
        end

        o_class.fwd_zone   = (fb <= bz) || (tel && (fb <= bzt));
        o_class.back_zone  = (fb >= AXIS_MAX_S - bz) || (tel && (fb >= AXIS_MAX_S - bzt));
        o_class.tel_lock   = tel && (i_sample.gear_a != 8'd0) && (i_sample.gear_b != 8'd0);
        o_class.synch_near = near_end(fb, ext15(i_cfg.synch_depth));
        o_class.exit_near  = near_end(fb, EXIT_DEPTH_S);
        o_class.grind_near = near_end(fb, ext15(i_cfg.grind_depth));
    end

endmodule

// ===== src/sgst_tracker.sv =====
// Tracker state registers and their next-state and change-flag logic.
module sgst_tracker
    import sgst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_class  i_class,
    output t_result o_result
);

    logic [2:0] r_slot;
    logic [2:0] r_zone;
    logic [1:0] r_syn;
    logic       r_grind;

    logic [2:0] n_slot;
    logic [2:0] n_zone;
    logic [1:0] n_syn;
    logic       n_grind;

    always_comb begin
        // An unknown classification keeps the previous slot.
        n_slot = (i_class.slot != SLOT_UNKNOWN) ? i_class.slot : r_slot;

        n_zone = ZONE_NONE;
        if (i_class.fwd_zone) begin
            case (n_slot)
                SLOT_LF: n_zone = ZONE_LF;
                SLOT_MF: n_zone = ZONE_MF;
                SLOT_RF: n_zone = ZONE_RF;
                default: n_zone = ZONE_NONE;
            endcase
        end else if (i_class.back_zone) begin
            case (n_slot)
                SLOT_LB: n_zone = ZONE_LB;
                SLOT_MB: n_zone = ZONE_MB;
                SLOT_RB: n_zone = ZONE_RB;
                default: n_zone = ZONE_NONE;
            endcase
        end

        if (i_class.tel_lock || i_class.synch_near) begin
            n_syn = SYN_IN;
        end else if (((r_syn == SYN_IN) || (r_syn == SYN_EXIT)) && i_class.exit_near) begin
            n_syn = SYN_EXIT;
        end else begin
            n_syn = SYN_ENTER;
        end

        // A grind lasts one sample, then may rise again.
        n_grind = !r_grind && (n_syn == SYN_ENTER) && i_class.grind_near;

        o_result.slot_code        = n_slot;
        o_result.slot_changed     = (n_slot != r_slot);
        o_result.button_zone      = n_zone;
        o_result.zone_changed     = (n_zone != r_zone);
        o_result.synchro_code     = n_syn;
        o_result.synchro_changed  = (n_syn != r_syn);
        o_result.grinding         = n_grind;
        o_result.grinding_changed = (n_grind != r_grind);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SLOT_UNKNOWN;
            r_zone  <= ZONE_NONE;
            r_syn   <= SYN_UNKNOWN;
            r_grind <= 1'b0;
        end else if (i_en) begin
            r_slot  <= n_slot;
            r_zone  <= n_zone;
            r_syn   <= n_syn;
            r_grind <= n_grind;
        end
    end

    a_grind_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_grind) |=> !r_grind)
        else $error("grinding held for two samples");

    a_slot_stays_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot != SLOT_UNKNOWN) |=> (r_slot != SLOT_UNKNOWN))
        else $error("slot fell back to unknown");

    a_zone_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zone != ZONE_NONE) |-> ((r_slot != SLOT_UNKNOWN) && (r_slot != SLOT_NEUTRAL)))
        else $error("button zone without a gear slot");

    a_grind_entering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grind |-> (r_syn == SYN_ENTER))
        else $error("grinding outside entering synch");

endmodule

// ===== src/shifter_gate_state_tracker.sv =====
// Top level of the shifter gate state tracker: channels, pipeline and config.
//
//   Channel    Dir  Handshake            Payload
//   i_sample   in   valid/ready          lr_position, fb_position, gear_a, gear_b
//   o_result   out  valid/ready          slot, zone, synchro, grinding + changed flags
//   i_cfg_*    in   i_cfg_we (no wait)   i_cfg_idx, i_cfg_data
//
// An accepted item sits in the input register until the result register is free; then
// it moves through the classifier and tracker into the result register, and its
// result is offered on o_result until it is taken.
// One item is accepted per cycle unless o_result stalls, since the tracker state is registered.
// Reset is synchronous and active low; it clears tracker state, valid flags and
// loads the configuration defaults.
// When the result is stalled, the input register still takes one more item.
module shifter_gate_state_tracker
    import sgst_pkg::*;
#(
    parameter int P_AXIS_MAX         = AXIS_MAX,
    parameter int P_EXIT_SYNCH_DEPTH = EXIT_SYNCH_DEPTH
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    sgst_in_if.sink          i_sample,
    sgst_out_if.source       o_result,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_class  cls;
    t_result res;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_result r_out;

    logic out_free;
    logic in_ready;
    logic fire;

    // The result register moves whenever it is empty or being taken.
    assign out_free = !r_out_valid || o_result.ready;
    assign in_ready = !r_in_valid || out_free;
    assign fire     = r_in_valid && out_free;

    assign i_sample.ready = in_ready;

    sgst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sgst_classify #(
        .P_AXIS_MAX         (P_AXIS_MAX),
        .P_EXIT_SYNCH_DEPTH (P_EXIT_SYNCH_DEPTH)
    ) u_classify (
        .i_cfg    (cfg),
        .i_sample (r_in),
        .o_class  (cls)
    );

    // Tracker state advances exactly when an item moves into the result register.
    sgst_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (fire),
        .i_class  (cls),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_sample.valid) begin
            r_in.lr_position <= i_sample.lr_position;
            r_in.fb_position <= i_sample.fb_position;
            r_in.gear_a      <= i_sample.gear_a;
            r_in.gear_b      <= i_sample.gear_b;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.slot_code        = r_out.slot_code;
    assign o_result.slot_changed     = r_out.slot_changed;
    assign o_result.button_zone      = r_out.button_zone;
    assign o_result.zone_changed     = r_out.zone_changed;
    assign o_result.synchro_code     = r_out.synchro_code;
    assign o_result.synchro_changed  = r_out.synchro_changed;
    assign o_result.grinding         = r_out.grinding;
    assign o_result.grinding_changed = r_out.grinding_changed;

endmodule
